// File: rtl/bve_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bit vector engine.
// Depends on nothing; every other file refers to it by scoped names.
package bve_pkg;

  localparam int WORDS  = 64;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int CNT_W  = $clog2(WORDS + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = 11;
  localparam int WIDX_W = POS_W - 5;
  localparam int CFG_W  = 7;

  // Index of the configuration register; its byte address is four times this.
  localparam logic REG_WORDS_IN_USE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_SET     = 3'd0,
    OP_CLR     = 3'd1,
    OP_RDBIT   = 3'd2,
    OP_RDFLD   = 3'd3,
    OP_FIND    = 3'd4,
    OP_INSERT  = 3'd5,
    OP_DELETE  = 3'd6,
    OP_CLR_ALL = 3'd7
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] bit_position;
    logic [POS_W-1:0] count_value;
    logic             find_value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              found;
    logic [POS_W-1:0]  found_position;
  } out_item_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_CLEAR_ALL,
    ACT_SET_CLR,
    ACT_RDBIT,
    ACT_FLD_LO,
    ACT_FLD_HI,
    ACT_FIND,
    ACT_INS,
    ACT_DEL,
    ACT_DEL_LAST,
    ACT_OUT
  } act_t;

  typedef struct packed {
    act_t              act;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } dp_cmd_t;

  typedef struct packed {
    op_t               op;
    logic              w_ok;
    logic [WIDX_W-1:0] w;
    logic [CNT_W-1:0]  nw;
    logic              hit;
    logic              find_end;
  } dp_sts_t;

endpackage

// File: rtl/bve_datapath.sv
`timescale 1ns / 1ps
// Datapath of the bit vector engine: word memory with valid bits, item and
// result registers, and the per-operation word arithmetic. Uses bve_pkg.
module bve_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bve_pkg::in_item_t        in_data,
  input  logic [bve_pkg::CFG_W-1:0] words_in_use,
  input  bve_pkg::dp_cmd_t         cmd,
  output bve_pkg::dp_sts_t         sts,
  output bve_pkg::out_item_t       out_data
);

  function automatic logic [bve_pkg::DATA_W-1:0] reverse32(
    input logic [bve_pkg::DATA_W-1:0] x
  );
    logic [bve_pkg::DATA_W-1:0] r;
    for (int i = 0; i < bve_pkg::DATA_W; i++) begin
      r[i] = x[bve_pkg::DATA_W-1-i];
    end
    return r;
  endfunction

  // Trailing zero count as a five-level halving search.
  function automatic logic [4:0] ctz32(input logic [31:0] m);
    logic [31:0] x;
    logic [4:0]  n;
    x = m;
    n = '0;
    if (x[15:0] == 16'd0) begin
      n[4] = 1'b1;
      x = x >> 16;
    end
    if (x[7:0] == 8'd0) begin
      n[3] = 1'b1;
      x = x >> 8;
    end
    if (x[3:0] == 4'd0) begin
      n[2] = 1'b1;
      x = x >> 4;
    end
    if (x[1:0] == 2'd0) begin
      n[1] = 1'b1;
      x = x >> 2;
    end
    if (x[0] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

  logic [bve_pkg::DATA_W-1:0] mem [bve_pkg::WORDS];
  logic [bve_pkg::WORDS-1:0]  vld_r;
  logic [bve_pkg::DATA_W-1:0] rdata_r;
  logic                       rvld_r;
  logic [bve_pkg::ADDR_W-1:0] rd_addr_q_r;

  bve_pkg::in_item_t  item_r;
  bve_pkg::out_item_t res_r;
  bve_pkg::out_item_t out_r;
  logic [bve_pkg::DATA_W-1:0] lo_r;
  logic [bve_pkg::DATA_W-1:0] prev_r;
  logic                       carry_r;

  bve_pkg::op_t               op;
  logic [bve_pkg::WIDX_W-1:0] w;
  logic [4:0]                 b;
  logic [bve_pkg::CNT_W-1:0]  nw;
  logic [bve_pkg::CNT_W-1:0]  w_ext;
  logic                       w_ok;
  logic                       w1_ok;
  logic [bve_pkg::DATA_W-1:0] rdq;
  logic [bve_pkg::DATA_W-1:0] bit1;
  logic [bve_pkg::DATA_W-1:0] low;
  logic                       first;
  logic [bve_pkg::DATA_W-1:0] skip;
  logic [bve_pkg::DATA_W-1:0] m;
  logic                       hit;
  logic [bve_pkg::WIDX_W-1:0] last_w;
  logic [bve_pkg::ADDR_W-1:0] last_a;
  logic [bve_pkg::POS_W-1:0]  fpos;
  logic [bve_pkg::CNT_W-1:0]  lim;
  logic [5:0]                 lim_c;
  logic [5:0]                 cntc;
  logic [bve_pkg::DATA_W-1:0] hi;
  logic [bve_pkg::DATA_W-1:0] ext;
  logic [bve_pkg::DATA_W-1:0] fld;
  logic                       wr_en;
  logic [bve_pkg::ADDR_W-1:0] wr_addr;
  logic [bve_pkg::DATA_W-1:0] wr_data;

  always_comb begin
    op    = bve_pkg::op_t'(item_r.operation);
    w     = item_r.bit_position[bve_pkg::POS_W-1:5];
    b     = item_r.bit_position[4:0];
    nw    = (words_in_use > bve_pkg::CFG_W'(bve_pkg::WORDS)) ?
            bve_pkg::CNT_W'(bve_pkg::WORDS) : bve_pkg::CNT_W'(words_in_use);
    w_ext = bve_pkg::CNT_W'(w);
    w_ok  = w_ext < nw;
    w1_ok = (w_ext + bve_pkg::CNT_W'(1)) < nw;
    rdq   = rvld_r ? rdata_r : '0;
    bit1  = 32'd1 << b;
    low   = bit1 - 32'd1;
    first = rd_addr_q_r == bve_pkg::ADDR_W'(w);

    // Find: skip words that hold nothing of interest.
    skip   = item_r.find_value ? '0 : '1;
    hit    = rdq != skip;
    m      = item_r.find_value ? rdq : ~rdq;
    last_w = item_r.count_value[bve_pkg::POS_W-1:5];
    last_a = (bve_pkg::CNT_W'(last_w) > bve_pkg::CNT_W'(bve_pkg::WORDS - 1)) ?
             bve_pkg::ADDR_W'(bve_pkg::WORDS - 1) : bve_pkg::ADDR_W'(last_w);
    fpos   = bve_pkg::POS_W'({rd_addr_q_r, ctz32(m)});

    // Read field: the run spans at most this word and the next one.
    lim   = nw - w_ext;
    lim_c = (lim > bve_pkg::CNT_W'(32)) ? 6'd32 : 6'(lim);
    cntc  = (item_r.count_value > bve_pkg::POS_W'(lim_c)) ? lim_c :
            6'(item_r.count_value);
    hi    = w1_ok ? rdq : '0;
    ext   = bve_pkg::DATA_W'({hi, lo_r} >> b);
    fld   = reverse32(ext) >> (6'd32 - cntc);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_q_r;
    wr_data = rdq;
    case (cmd.act)
      bve_pkg::ACT_SET_CLR: begin
        wr_en   = 1'b1;
        wr_data = (op == bve_pkg::OP_SET) ? (rdq | bit1) : (rdq & ~bit1);
      end
      bve_pkg::ACT_INS: begin
        wr_en   = 1'b1;
        wr_data = first ? ((rdq & low) | ((rdq & ~low & 32'h7fff_ffff) << 1)) :
                  {rdq[bve_pkg::DATA_W-2:0], carry_r};
      end
      bve_pkg::ACT_DEL: begin
        wr_en   = !first;
        wr_addr = rd_addr_q_r - bve_pkg::ADDR_W'(1);
        wr_data = prev_r | {rdq[0], {(bve_pkg::DATA_W-1){1'b0}}};
      end
      bve_pkg::ACT_DEL_LAST: begin
        wr_en   = 1'b1;
        wr_data = prev_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r     <= mem[cmd.rd_addr];
      rvld_r      <= vld_r[cmd.rd_addr];
      rd_addr_q_r <= cmd.rd_addr;
    end
  end

  // A word that was never written since reset or clear all reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.act == bve_pkg::ACT_CLEAR_ALL) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.act)
      bve_pkg::ACT_LOAD: begin
        item_r <= in_data;
        res_r  <= '0;
      end
      bve_pkg::ACT_RDBIT: begin
        res_r.read_data <= bve_pkg::DATA_W'(rdq[b]);
      end
      bve_pkg::ACT_FLD_LO: begin
        lo_r <= rdq;
      end
      bve_pkg::ACT_FLD_HI: begin
        res_r.read_data <= fld;
      end
      bve_pkg::ACT_FIND: begin
        if (hit) begin
          res_r.found          <= 1'b1;
          res_r.found_position <= fpos;
        end
      end
      bve_pkg::ACT_INS: begin
        carry_r <= rdq[bve_pkg::DATA_W-1];
      end
      bve_pkg::ACT_DEL: begin
        prev_r <= first ? ((rdq & low) | ((rdq >> 1) & ~low)) : (rdq >> 1);
      end
      bve_pkg::ACT_OUT: begin
        out_r <= res_r;
      end
      default: begin
        out_r <= out_r;
      end
    endcase
  end

  always_comb begin
    sts.op       = op;
    sts.w_ok     = w_ok;
    sts.w        = w;
    sts.nw       = nw;
    sts.hit      = hit;
    sts.find_end = rd_addr_q_r == last_a;
  end

  assign out_data = out_r;

endmodule

// File: rtl/bve_ctrl.sv
`timescale 1ns / 1ps
// Controller of the bit vector engine: sequences memory reads and datapath
// actions per operation and owns both handshakes. Uses bve_pkg.
module bve_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bve_pkg::dp_sts_t  sts,
  output bve_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_WORD,
    ST_FLD_LO,
    ST_FLD_HI,
    ST_SCAN,
    ST_INS,
    ST_DEL,
    ST_DEL_LAST,
    ST_DONE
  } state_t;

  state_t                    st_r;
  state_t                    st_nxt;
  logic [bve_pkg::CNT_W-1:0] idx_r;
  logic [bve_pkg::CNT_W-1:0] idx_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;

  always_comb begin
    st_nxt        = st_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.act       = bve_pkg::ACT_NONE;
    cmd.rd_en     = 1'b0;
    cmd.rd_addr   = idx_r[bve_pkg::ADDR_W-1:0];
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.act = bve_pkg::ACT_LOAD;
          st_nxt  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.op)
          bve_pkg::OP_CLR_ALL: begin
            cmd.act = bve_pkg::ACT_CLEAR_ALL;
            st_nxt  = ST_DONE;
          end
          bve_pkg::OP_FIND: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = '0;
            idx_nxt     = bve_pkg::CNT_W'(1);
            st_nxt      = ST_SCAN;
          end
          default: begin
            if (!sts.w_ok) begin
              st_nxt = ST_DONE;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_addr = bve_pkg::ADDR_W'(sts.w);
              idx_nxt     = bve_pkg::CNT_W'(sts.w) + bve_pkg::CNT_W'(1);
              case (sts.op) inside
                bve_pkg::OP_SET, bve_pkg::OP_CLR, bve_pkg::OP_RDBIT: begin
                  st_nxt = ST_WORD;
                end
                bve_pkg::OP_RDFLD: begin
                  st_nxt = ST_FLD_LO;
                end
                bve_pkg::OP_INSERT: begin
                  st_nxt = ST_INS;
                end
                default: begin
                  st_nxt = ST_DEL;
                end
              endcase
            end
          end
        endcase
      end
      ST_WORD: begin
        cmd.act = (sts.op == bve_pkg::OP_RDBIT) ? bve_pkg::ACT_RDBIT :
                  bve_pkg::ACT_SET_CLR;
        st_nxt  = ST_DONE;
      end
      ST_FLD_LO: begin
        cmd.act     = bve_pkg::ACT_FLD_LO;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = bve_pkg::ADDR_W'(sts.w) + bve_pkg::ADDR_W'(1);
        st_nxt      = ST_FLD_HI;
      end
      ST_FLD_HI: begin
        cmd.act = bve_pkg::ACT_FLD_HI;
        st_nxt  = ST_DONE;
      end
      ST_SCAN: begin
        cmd.act = bve_pkg::ACT_FIND;
        if (sts.hit || sts.find_end) begin
          st_nxt = ST_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + bve_pkg::CNT_W'(1);
        end
      end
      ST_INS: begin
        cmd.act = bve_pkg::ACT_INS;
        if (idx_r < sts.nw) begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + bve_pkg::CNT_W'(1);
        end else begin
          st_nxt = ST_DONE;
        end
      end
      ST_DEL: begin
        cmd.act = bve_pkg::ACT_DEL;
        if (idx_r < sts.nw) begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + bve_pkg::CNT_W'(1);
        end else begin
          st_nxt = ST_DEL_LAST;
        end
      end
      ST_DEL_LAST: begin
        cmd.act = bve_pkg::ACT_DEL_LAST;
        st_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.act       = bve_pkg::ACT_OUT;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = st_r != ST_IDLE;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.act == bve_pkg::ACT_OUT |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while a result is pending");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> st_r == ST_DISPATCH)
    else $error("accepted transaction was not dispatched");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_INS || st_r == ST_DEL) |-> idx_r <= sts.nw)
    else $error("word walk ran past the words in use");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE || st_r == ST_DONE) |-> !cmd.rd_en)
    else $error("memory read issued outside an operation");
`endif

endmodule

// File: rtl/bit_vector_engine.sv
`timescale 1ns / 1ps
// Steps: set/clear/read bit read word w, read field words w and w+1, find scans k words
// (up to 64), insert walks words w to nw-1, delete too with one more write; clear all
// and non-find operations on a word outside the words in use go straight to done. One
// transaction at a time; find, insert and delete walk the words through one read port.
// Reset (rst_n low, synchronous) zeroes the vector at once through per-word valid
// bits, sets words_in_use to 64 and empties the result register; no clearing pass.
module bit_vector_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input transaction channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bve_pkg::in_item_t    in_data,
  // Result transaction channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output bve_pkg::out_item_t   out_data,
  // Configuration port; words_in_use sits at byte address 0.
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // The configuration register. Write it only while the engine is idle (the block does
  // not enforce this), so the datapath may read it freely during an operation.
  logic [bve_pkg::CFG_W-1:0] words_in_use_r;
  logic                      cfg_wr;

  bve_pkg::dp_cmd_t cmd;
  bve_pkg::dp_sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_in_use_r <= bve_pkg::CFG_W'(bve_pkg::WORDS);
    end else if (cfg_wr && paddr[2] == bve_pkg::REG_WORDS_IN_USE) begin
      words_in_use_r <= pwdata[bve_pkg::CFG_W-1:0];
    end
  end

  // Address bit 2 selects the register; anything past the list reads zero.
  assign prdata = (paddr[2] == bve_pkg::REG_WORDS_IN_USE) ? 32'(words_in_use_r) : '0;

  // The controller walks the words and drives both handshakes; the result
  // register in the datapath lets a new transaction be accepted while the
  // previous result still waits on a stalled output.
  bve_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the word memory, its valid bits and all payload.
  bve_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .words_in_use (words_in_use_r),
    .cmd          (cmd),
    .sts          (sts),
    .out_data     (out_data)
  );

endmodule

// File: tb/bit_vector_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bit_vector_engine: directed and random transactions.
// Depends on bve_pkg and the bit_vector_engine RTL; needs no files or arguments.
module bit_vector_engine_tb;

  // Generous cap on total run time; the slowest legal run needs well under a fifth of it.
  localparam int unsigned TIMEOUT_NS = 50_000_000;
  // Cycles to keep watching after the last result, about the longest latency plus margin.
  localparam int unsigned DRAIN_CYCLES = 80;
  // Number of reporting slots before mismatches are only counted.
  localparam int unsigned REPORT_LIMIT = 10;

  // Clock, reset and every block input start at known values.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  bve_pkg::in_item_t   in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bve_pkg::out_item_t  out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Shadow copy of the vector and of words_in_use, kept in step with accepted transactions.
  logic [31:0] shadow_vector [bve_pkg::WORDS];
  int unsigned shadow_words_cfg;

  // Items waiting to be driven, and results predicted but not yet seen.
  bve_pkg::in_item_t   pending_items[$];
  bve_pkg::out_item_t  expected_results[$];

  int unsigned queued_total = 0;    // transactions handed to the driver
  int unsigned accepted_total = 0;  // transactions the block has taken
  int unsigned result_total = 0;    // results the block has delivered
  int unsigned error_count = 0;
  bit          idle_on = 1'b1;      // when clear, neither side inserts gaps
  bit          drain_hold = 1'b0;   // sender waits for all results before the next item
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;

  bit_vector_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // The register may exceed the store size; the block then uses every word it has.
  function automatic int unsigned effective_words();
    return (shadow_words_cfg < bve_pkg::WORDS) ? shadow_words_cfg : bve_pkg::WORDS;
  endfunction

  // A bit whose word lies outside the words in use always reads as zero.
  function automatic logic vector_bit(input int unsigned p);
    int unsigned w;
    w = p >> 5;
    if (w >= effective_words()) return 1'b0;
    return shadow_vector[w][p & 31];
  endfunction

  // Applies one operation to the shadow vector and returns the result the block owes.
  function automatic bve_pkg::out_item_t apply_operation(input bve_pkg::in_item_t item);
    bve_pkg::out_item_t res;
    int unsigned nw, w, b, cnt, lim, scan_end, i, j;
    logic [31:0] low_mask, blk, skip_word, m;
    logic        carry, nb, hit;
    res = '0;
    nw = effective_words();
    w = 32'(item.bit_position) >> 5;
    b = 32'(item.bit_position[4:0]);
    low_mask = (32'd1 << b) - 32'd1;
    case (bve_pkg::op_t'(item.operation))
      bve_pkg::OP_SET: begin
        if (w < nw) shadow_vector[w][b] = 1'b1;
      end
      bve_pkg::OP_CLR: begin
        if (w < nw) shadow_vector[w][b] = 1'b0;
      end
      bve_pkg::OP_RDBIT: begin
        res.read_data = {31'd0, vector_bit(32'(item.bit_position))};
      end
      bve_pkg::OP_RDFLD: begin
        // The field length is limited in words, not bits, from the starting word.
        if (w < nw) begin
          lim = (nw - w > 32) ? 32 : nw - w;
          cnt = (32'(item.count_value) > lim) ? lim : 32'(item.count_value);
          for (i = 0; i < cnt; i++)
            res.read_data[cnt - 1 - i] = vector_bit(32'(item.bit_position) + i);
        end
      end
      bve_pkg::OP_FIND: begin
        // The scan ignores words_in_use and stops at the word holding count_value, at most the last word of the store.
        scan_end = 32'(item.count_value) >> 5;
        if (scan_end > bve_pkg::WORDS - 1) scan_end = bve_pkg::WORDS - 1;
        skip_word = item.find_value ? 32'd0 : 32'hffff_ffff;
        hit = 1'b0;
        for (i = 0; i <= scan_end && !hit; i++) begin
          if (shadow_vector[i] != skip_word) begin
            m = item.find_value ? shadow_vector[i] : ~shadow_vector[i];
            j = 0;
            while (!m[j]) j++;
            hit = 1'b1;
            res.found = 1'b1;
            res.found_position = bve_pkg::POS_W'(i * 32 + j);
          end
        end
      end
      bve_pkg::OP_INSERT: begin
        if (w < nw) begin
          blk = shadow_vector[w];
          carry = blk[31];
          shadow_vector[w] = (blk & low_mask) | ((blk & ~low_mask & 32'h7fff_ffff) << 1);
          for (i = w + 1; i < nw; i++) begin
            blk = shadow_vector[i];
            nb = blk[31];
            shadow_vector[i] = {blk[30:0], carry};
            carry = nb;
          end
        end
      end
      bve_pkg::OP_DELETE: begin
        if (w < nw) begin
          blk = shadow_vector[w];
          shadow_vector[w] = (blk & low_mask) | ((blk >> 1) & ~low_mask);
          for (i = w + 1; i < nw; i++) begin
            if (shadow_vector[i][0]) shadow_vector[i - 1][31] = 1'b1;
            shadow_vector[i] = shadow_vector[i] >> 1;
          end
        end
      end
      bve_pkg::OP_CLR_ALL: begin
        // Clears the whole store, including words beyond words_in_use.
        for (i = 0; i < bve_pkg::WORDS; i++) shadow_vector[i] = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Gap or stall length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_item(input bve_pkg::op_t op, input int unsigned pos,
                                     input int unsigned cnt, input bit val);
    bve_pkg::in_item_t item;
    item.operation    = op;
    item.bit_position = bve_pkg::POS_W'(pos);
    item.count_value  = bve_pkg::POS_W'(cnt);
    item.find_value   = val;
    pending_items.push_back(item);
    queued_total++;
  endfunction

  // Positions mostly fall inside the words in use, the rest anywhere in the 11-bit range.
  function automatic int unsigned rand_pos(input int unsigned eff);
    if (eff != 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, eff * 32 - 1);
    return $urandom_range(0, 2047);
  endfunction

  // Returns once every queued transaction has been taken and every result has come back.
  // The counters are compared rather than the valid line, so the check does not depend on
  // the order in which processes run at a clock edge.
  task automatic wait_quiet();
    do @(posedge clk);
    while (accepted_total != queued_total || expected_results.size() != 0);
  endtask

  // One APB write: a setup phase, then an access phase held until pready.
  task automatic write_words_in_use(input logic [6:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {bve_pkg::REG_WORDS_IN_USE, 2'b00};
    pwdata  <= {25'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    // The register took the value at this edge; the block is idle, so the shadow follows.
    shadow_words_cfg = 32'(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Input driver. A transaction completes at an edge where in_valid is high and in_stall is
  // low; the expected result is predicted right then, against the state the block also sees.
  // The payload only moves when the channel is free, so a stalled item never changes, and
  // in_valid gets at most one assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_operation(in_data));
        accepted_total++;
        // Once in a while the sender lets the block drain completely.
        if ($urandom_range(0, 199) == 0) drain_hold = 1'b1;
      end
      if (!in_valid || !in_stall) begin
        if (drain_hold && expected_results.size() != 0) begin
          in_valid <= 1'b0;
        end else if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          drain_hold = 1'b0;
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each delivered result is checked field by field against the oldest
  // prediction; the stall line is then redrawn for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        result_total++;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("result %0d arrived with none expected: read_data=%h found=%b pos=%0d",
                     result_total, out_data.read_data, out_data.found,
                     out_data.found_position);
        end else begin
          if (out_data.read_data !== expected_results[0].read_data ||
              out_data.found !== expected_results[0].found ||
              out_data.found_position !== expected_results[0].found_position) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("result %0d mismatch: expected read_data=%h found=%b pos=%0d, got %s",
                       result_total, expected_results[0].read_data,
                       expected_results[0].found, expected_results[0].found_position,
                       $sformatf("read_data=%h found=%b pos=%0d", out_data.read_data,
                                 out_data.found, out_data.found_position));
          end
          void'(expected_results.pop_front());
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // Stimulus: a directed opening at the reset configuration, then random phases, each one
  // under its own words_in_use value, written while the block is idle from the second phase on.
  initial begin
    int unsigned  ph, made, words, eff, op_pick, run_len, run_start, k, cnt, phase_len;
    bve_pkg::op_t op;

    for (k = 0; k < bve_pkg::WORDS; k++) shadow_vector[k] = '0;
    shadow_words_cfg = bve_pkg::WORDS;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: corners of the vector, every operation, clamped field lengths,
    // finds that hit and miss, and shifts at both ends and in the middle of a word.
    queue_item(bve_pkg::OP_SET,     0,    0,    1'b0);
    queue_item(bve_pkg::OP_SET,     2047, 2047, 1'b1);
    queue_item(bve_pkg::OP_SET,     31,   0,    1'b0);
    queue_item(bve_pkg::OP_SET,     32,   0,    1'b0);
    queue_item(bve_pkg::OP_RDBIT,   0,    0,    1'b0);
    queue_item(bve_pkg::OP_RDBIT,   2047, 0,    1'b0);
    queue_item(bve_pkg::OP_RDFLD,   0,    32,   1'b0);
    queue_item(bve_pkg::OP_RDFLD,   2040, 32,   1'b0);  // last word: length shrinks to one
    queue_item(bve_pkg::OP_RDFLD,   5,    0,    1'b0);  // zero length reads zero
    queue_item(bve_pkg::OP_RDFLD,   30,   2047, 1'b1);  // length clamps to 32
    queue_item(bve_pkg::OP_FIND,    0,    2047, 1'b1);
    queue_item(bve_pkg::OP_FIND,    0,    0,    1'b0);
    queue_item(bve_pkg::OP_INSERT,  0,    0,    1'b0);
    queue_item(bve_pkg::OP_INSERT,  2047, 0,    1'b0);
    queue_item(bve_pkg::OP_INSERT,  40,   0,    1'b0);
    queue_item(bve_pkg::OP_DELETE,  0,    0,    1'b0);
    queue_item(bve_pkg::OP_DELETE,  2047, 0,    1'b0);
    queue_item(bve_pkg::OP_DELETE,  40,   0,    1'b0);
    queue_item(bve_pkg::OP_RDBIT,   33,   0,    1'b0);
    queue_item(bve_pkg::OP_CLR,     32,   0,    1'b0);
    queue_item(bve_pkg::OP_RDFLD,   0,    64,   1'b0);
    queue_item(bve_pkg::OP_CLR_ALL, 2047, 2047, 1'b1);
    queue_item(bve_pkg::OP_FIND,    0,    2047, 1'b1);  // empty store: nothing found
    queue_item(bve_pkg::OP_FIND,    0,    2047, 1'b0);
    wait_quiet();

    // Phases: reset value, one word, zero words, an oversized value, full size, then
    // random sizes. Every third phase runs with no gaps or stalls at all.
    for (ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       words = 64;
        1:       words = 1;
        2:       words = 0;
        3:       words = 127;
        4:       words = 64;
        default: words = $urandom_range(1, 64);
      endcase
      if (ph != 0) write_words_in_use(words[6:0]);
      idle_on = (ph % 3 != 2);
      eff = effective_words();
      phase_len = (eff == 0) ? 40 : 250;
      made = 0;
      while (made < phase_len) begin
        op_pick = $urandom_range(0, 99);
        if (op_pick < 3 && eff != 0) begin
          // A run of consecutive sets from a word boundary fills whole words, so finds for
          // a clear bit and shifts across full words get exercised.
          run_start = $urandom_range(0, eff - 1) * 32;
          run_len = $urandom_range(32, 96);
          for (k = 0; k < run_len; k++)
            queue_item(bve_pkg::OP_SET, (run_start + k) % 2048, $urandom_range(0, 2047),
                       1'($urandom_range(0, 1)));
          made += run_len;
        end else begin
          if      (op_pick < 30) op = bve_pkg::OP_SET;
          else if (op_pick < 40) op = bve_pkg::OP_CLR;
          else if (op_pick < 52) op = bve_pkg::OP_RDBIT;
          else if (op_pick < 64) op = bve_pkg::OP_RDFLD;
          else if (op_pick < 78) op = bve_pkg::OP_FIND;
          else if (op_pick < 87) op = bve_pkg::OP_INSERT;
          else if (op_pick < 99) op = bve_pkg::OP_DELETE;
          else                   op = bve_pkg::OP_CLR_ALL;
          if (op == bve_pkg::OP_RDFLD && $urandom_range(0, 99) < 70)
            cnt = $urandom_range(0, 33);
          else if (op == bve_pkg::OP_FIND && $urandom_range(0, 1) == 1)
            cnt = $urandom_range(0, (eff * 32 + 31 > 2047) ? 2047 : eff * 32 + 31);
          else
            cnt = $urandom_range(0, 2047);
          queue_item(op, rand_pos(eff), cnt, 1'($urandom_range(0, 1)));
          made++;
        end
      end
      // The sender holds off here until every result of the phase is back.
      wait_quiet();
      repeat (4) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("** bit_vector_engine: PASSED **");
    end else begin
      $display("** bit_vector_engine: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout: the handshake stopped moving");
    $display("** bit_vector_engine: FAILED **");
    $finish;
  end

endmodule
